@@ design/brb_pkg.sv @@
package brb_pkg;

  localparam int DEPTH = 64;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_TAKE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [6:0] max_count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  function automatic logic [PW-1:0] add_mod(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PW+1)'(DEPTH)) sum = sum - (PW+1)'(DEPTH);
    return sum[PW-1:0];
  endfunction

  function automatic logic [CW-1:0] fill_of(logic [PW-1:0] wp, logic [PW-1:0] rp,
                                            logic full);
    logic [PW:0] d;
    d = {1'b0, wp} + (PW+1)'(DEPTH) - {1'b0, rp};
    if (d >= (PW+1)'(DEPTH)) d = d - (PW+1)'(DEPTH);
    if (full) return CW'(DEPTH);
    return CW'(d);
  endfunction

endpackage

@@ design/brb_front.sv @@
module brb_front import brb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  input  logic [6:0] max_count,
  output logic       busy,
  output cmd_beat_t  q,
  input  logic       q_pop
);

  cmd_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy  = (count == 2'd2);
  assign push  = start && !busy;
  assign q.valid = (count != 2'd0);
  assign q.cmd   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= '{op: opcode, data: data_byte, max_count: max_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ design/brb_back.sv @@
module brb_back import brb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_beat_t  q,
  output logic       q_pop,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       last,
  output logic [1:0] status,
  output logic       word_found,
  output logic [6:0] fill_level
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BSCAN = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_TLEN  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic [PW-1:0] rd_addr;
  logic          mem_we;

  // suffix flags per offset: {has delim, delim then non-delim, word}
  logic [2:0]    sfx [DEPTH];
  logic [2:0]    sfx_q;
  logic [2:0]    sf_cur;
  logic [PW-1:0] sf_addr;
  logic          sf_we;

  logic [2:0]    state;
  cmd_t          cur;
  logic [PW-1:0] rp, wp;
  logic          full;
  logic [7:0]    delim;
  logic          dirty;
  logic          hd, dn, fd;
  logic [CW-1:0] nb;
  logic [CW-1:0] fill;

  logic [CW-1:0] scan_idx, scan_left, pend_idx;
  logic          pend_valid;
  logic          r_hd, r_hn, r_nd, r_dn, r_f;
  logic          have;
  logic [CW-1:0] s_off, e_off;
  logic [CW-1:0] j, jend;

  logic          is_d;
  logic          b_hd, b_hn, b_nd, b_dn, b_f;
  logic          p_d, p_hd, p_dn, p_fd;
  logic [PW-1:0] wp_inc;
  logic [6:0]    cnt;
  logic [CW:0]   tlen;
  logic [CW-1:0] j1;

  assign fill  = fill_of(wp, rp, full);
  assign q_pop = (state == S_IDLE) && q.valid;

  // suffix flags, walked from newest to oldest
  assign is_d = (mem_q == delim);
  assign b_f  = r_f  | (is_d & r_nd);
  assign b_nd = r_nd | (!is_d & r_hd);
  assign b_dn = r_dn | (is_d & r_hn);
  assign b_hd = r_hd | is_d;
  assign b_hn = r_hn | !is_d;

  // push update of the running flags
  assign p_d    = (cur.data == delim);
  assign p_fd   = fd | (dn & p_d);
  assign p_dn   = dn | (hd & !p_d);
  assign p_hd   = hd | p_d;
  assign wp_inc = add_mod(wp, PW'(1));

  assign cnt  = (cur.max_count < 7'(nb)) ? cur.max_count : 7'(nb);
  assign tlen = {1'b0, e_off} - {1'b0, s_off} + (CW+1)'(1);
  assign j1   = j + CW'(1);

  assign mem_we = (state == S_EXEC) && (cur.op == OP_PUSH) && !full;
  assign sf_we  = (state == S_BSCAN) && pend_valid;
  // nothing is left once the last stored byte goes
  assign sf_cur = (j1 == nb) ? 3'b000 : sfx_q;

  always_comb begin
    case (state)
      S_BSCAN, S_FSCAN: rd_addr = add_mod(rp, scan_idx[PW-1:0]);
      S_EMIT:           rd_addr = add_mod(rp, PW'(1));
      default:          rd_addr = rp;
    endcase
    case (state)
      S_RD:    sf_addr = j1[PW-1:0];
      S_EMIT:  sf_addr = PW'(j1 + CW'(1));
      default: sf_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wp] <= cur.data;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sf_we) sfx[pend_idx[PW-1:0]] <= {b_hd, b_dn, b_f};
    sfx_q <= sfx[sf_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rp         <= '0;
      wp         <= '0;
      full       <= 1'b0;
      delim      <= 8'd0;
      dirty      <= 1'b0;
      hd         <= 1'b0;
      dn         <= 1'b0;
      fd         <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      if (cfg_valid) begin
        delim <= cfg_data;
        dirty <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q.valid) begin
            cur <= q.cmd;
            nb  <= fill;
            if (dirty || q.cmd.op == OP_POP || q.cmd.op == OP_TAKE) begin
              scan_idx   <= fill - CW'(1);
              scan_left  <= fill;
              pend_valid <= 1'b0;
              {r_hd, r_hn, r_nd, r_dn, r_f} <= '0;
              state <= S_BSCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_BSCAN: begin
          if (scan_left != '0) begin
            pend_valid <= 1'b1;
            pend_idx   <= scan_idx;
            scan_idx   <= scan_idx - CW'(1);
            scan_left  <= scan_left - CW'(1);
          end else begin
            pend_valid <= 1'b0;
          end
          if (pend_valid) begin
            {r_hd, r_hn, r_nd, r_dn, r_f} <= {b_hd, b_hn, b_nd, b_dn, b_f};
          end
          if (scan_left == '0 && !pend_valid) begin
            hd    <= r_hd;
            dn    <= r_dn;
            fd    <= r_f;
            dirty <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_byte <= 8'd0;
          case (cur.op)
            OP_PUSH: begin
              strobe <= 1'b1;
              last   <= 1'b1;
              state  <= S_IDLE;
              if (full) begin
                status     <= ST_OVERFLOW;
                word_found <= fd;
                fill_level <= 7'(nb);
              end else begin
                wp         <= wp_inc;
                full       <= (wp_inc == rp);
                hd         <= p_hd;
                dn         <= p_dn;
                fd         <= p_fd;
                status     <= ST_OK;
                word_found <= p_fd;
                fill_level <= 7'(nb + CW'(1));
              end
            end
            OP_POP: begin
              if (nb == '0 || cur.max_count == 7'd0) begin
                strobe     <= 1'b1;
                last       <= 1'b1;
                status     <= (nb == '0) ? ST_EMPTY : ST_OK;
                word_found <= fd;
                fill_level <= 7'(nb);
                state      <= S_IDLE;
              end else begin
                j     <= '0;
                jend  <= CW'(cnt - 7'd1);
                state <= S_RD;
              end
            end
            OP_CHECK: begin
              strobe     <= 1'b1;
              last       <= 1'b1;
              status     <= fd ? ST_OK : ST_EMPTY;
              word_found <= fd;
              fill_level <= 7'(nb);
              state      <= S_IDLE;
            end
            default: begin
              if (!fd) begin
                strobe     <= 1'b1;
                last       <= 1'b1;
                status     <= ST_EMPTY;
                word_found <= 1'b0;
                fill_level <= 7'(nb);
                state      <= S_IDLE;
              end else begin
                scan_idx   <= '0;
                scan_left  <= nb;
                pend_valid <= 1'b0;
                have       <= 1'b0;
                s_off      <= '0;
                state      <= S_FSCAN;
              end
            end
          endcase
        end
        S_FSCAN: begin
          if (scan_left != '0) begin
            pend_valid <= 1'b1;
            pend_idx   <= scan_idx;
            scan_idx   <= scan_idx + CW'(1);
            scan_left  <= scan_left - CW'(1);
          end else begin
            pend_valid <= 1'b0;
          end
          if (pend_valid && is_d) begin
            if (have && (pend_idx - s_off) >= CW'(2)) begin
              e_off <= pend_idx;
              state <= S_TLEN;
            end else begin
              have  <= 1'b1;
              s_off <= pend_idx;
            end
          end else if (scan_left == '0 && !pend_valid) begin
            strobe     <= 1'b1;
            last       <= 1'b1;
            out_byte   <= 8'd0;
            status     <= ST_EMPTY;
            word_found <= fd;
            fill_level <= 7'(nb);
            state      <= S_IDLE;
          end
        end
        S_TLEN: begin
          if (tlen > (CW+1)'(cur.max_count)) begin
            strobe     <= 1'b1;
            last       <= 1'b1;
            out_byte   <= 8'd0;
            status     <= ST_TOO_LONG;
            word_found <= fd;
            fill_level <= 7'(nb);
            state      <= S_IDLE;
          end else begin
            rp <= add_mod(rp, s_off[PW-1:0]);
            if (s_off != '0) full <= 1'b0;
            j     <= s_off;
            jend  <= e_off;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          out_byte   <= mem_q;
          status     <= ST_OK;
          word_found <= sf_cur[0];
          fill_level <= 7'(nb - j1);
          rp         <= add_mod(rp, PW'(1));
          full       <= 1'b0;
          j          <= j1;
          if (j == jend) begin
            last  <= 1'b1;
            hd    <= sf_cur[2];
            dn    <= sf_cur[1];
            fd    <= sf_cur[0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/byte_ring_buffer_with_delimited_frames.sv @@
// Byte ring FIFO, 64 bytes, with delimiter-framed words.
// Command channel: an operation is taken at a clock edge with start high and
// busy low. Up to two operations queue ahead of the executor; busy is high
// while that queue is full.
// Config channel: cfg_valid/cfg_ready carry the delimiter byte; cfg_ready is
// always high. Write it only while the block is idle.
// Results: each beat sits on the result ports for one cycle, flagged by
// strobe, with last on the final beat of an operation. The receiver cannot
// stall; every beat must be taken as it appears.
// Push and check run a backward search over the stored bytes first only when
// the delimiter has been rewritten since the last search; pop and take always
// run it. Pop then streams its bytes, one byte per cycle; an empty or
// zero-count pop gives a single beat. Take adds a forward search before its
// bytes.
// Searches walk the store through its single registered read port.
// Reset (rst, synchronous) empties the store and sets the delimiter to 0.
module byte_ring_buffer_with_delimited_frames import brb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  input  logic [6:0] max_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic       last,
  output logic [1:0] status,
  output logic       word_found,
  output logic [6:0] fill_level
);

  cmd_beat_t q;
  logic      q_pop;

  assign cfg_ready = 1'b1;

  brb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .data_byte (data_byte),
    .max_count (max_count),
    .busy      (busy),
    .q         (q),
    .q_pop     (q_pop)
  );

  brb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q          (q),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .last       (last),
    .status     (status),
    .word_found (word_found),
    .fill_level (fill_level)
  );

endmodule
